### hdl/tbfe_pkg.sv
`default_nettype none

package tbfe_pkg;

  localparam int TAG_REG_W = 5;
  localparam int NUM_TAGS  = 8;
  localparam int CFG_IDX_W = 3;

  // input operation codes
  typedef enum logic [3:0] {
    OP_BOOL    = 4'd0,
    OP_BYTE    = 4'd1,
    OP_U32     = 4'd2,
    OP_S32     = 4'd3,
    OP_U64     = 4'd4,
    OP_FLOAT   = 4'd5,
    OP_STRING  = 4'd6,
    OP_BLOB    = 4'd7,
    OP_RAW     = 4'd8,
    OP_FLUSH   = 4'd9
  } op_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TAG_BOOL   = 3'd0,
    CFG_TAG_BYTE   = 3'd1,
    CFG_TAG_U32    = 3'd2,
    CFG_TAG_S32    = 3'd3,
    CFG_TAG_U64    = 3'd4,
    CFG_TAG_FLOAT  = 3'd5,
    CFG_TAG_STRING = 3'd6,
    CFG_TAG_BLOB   = 3'd7
  } cfg_idx_t;

  typedef logic [TAG_REG_W-1:0] tag_t;

  function automatic tag_t tag_reset_value(input cfg_idx_t idx);
    tag_t v;
    case (idx)
      CFG_TAG_BOOL:   v = 5'd1;
      CFG_TAG_BYTE:   v = 5'd3;
      CFG_TAG_U32:    v = 5'd8;
      CFG_TAG_S32:    v = 5'd7;
      CFG_TAG_U64:    v = 5'd10;
      CFG_TAG_FLOAT:  v = 5'd13;
      CFG_TAG_STRING: v = 5'd16;
      CFG_TAG_BLOB:   v = 5'd19;
      default:        v = 5'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### hdl/typed_bitstream_field_encoder.sv
// Typed bit packer, lsb first. Each word on the in_ channel is an operation and a 64-bit
// value; typed operations emit a TAG_BITS-wide tag from the cfg_ registers and then the
// payload, raw bytes emit 8 bits, and flush pads the partial byte with zeros and marks it
// end_of_stream. Completed bytes leave one per cycle on the out_ channel while out_ready
// allows, the last byte caused by each input word flagged by out_last_in_run. A front stage
// classifies each word into a run of up to TAG_BITS+64 bits and hands it through a two-word
// queue to the byte emitter, which holds the partial byte. The emitter takes a new word only
// once fewer than eight bits remain after any byte it emits, a word completes at most 9 bytes
// with the default tag width, and the next word merges in the same cycle the last byte of
// the previous one leaves. Unused operation codes are accepted and dropped. Tag registers
// must be written through cfg_ only while the block is idle; this is not enforced.
`default_nettype none

module typed_bitstream_field_encoder
  import tbfe_pkg::*;
#(
  parameter int TAG_BITS = 5
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [3:0]           in_operation,
  input  wire logic [63:0]          in_value,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [7:0]                out_byte,
  output logic                      out_last_in_run,
  output logic                      out_end_of_stream,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [TAG_REG_W-1:0] cfg_wdata
);

  localparam int CHUNK_W = TAG_BITS + 64;
  localparam int NB_W    = $clog2(CHUNK_W + 1);
  localparam int ENTRY_W = 1 + NB_W + CHUNK_W;

  logic               push_valid, push_ready;
  logic [ENTRY_W-1:0] push_data;
  logic               q_valid, q_ready;
  logic [ENTRY_W-1:0] q_data;

  tbfe_front #(
    .TAG_BITS (TAG_BITS),
    .CHUNK_W  (CHUNK_W),
    .NB_W     (NB_W),
    .ENTRY_W  (ENTRY_W)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_value     (in_value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_data    (push_data)
  );

  tbfe_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  tbfe_back #(
    .TAG_BITS (TAG_BITS),
    .CHUNK_W  (CHUNK_W),
    .NB_W     (NB_W),
    .ENTRY_W  (ENTRY_W)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_ready           (q_ready),
    .q_data            (q_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_last_in_run   (out_last_in_run),
    .out_end_of_stream (out_end_of_stream)
  );

endmodule

`default_nettype wire

### hdl/tbfe_queue.sv
`default_nettype none

module tbfe_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);

  logic [WIDTH-1:0] slot_r [2];
  logic             wptr_r, wptr_nxt;
  logic             rptr_r, rptr_nxt;
  logic [1:0]       fill_r, fill_nxt;
  logic             do_push, do_pop;

  assign push_ready = (fill_r != 2'd2);
  assign pop_valid  = (fill_r != 2'd0);
  assign pop_data   = slot_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wptr_nxt = do_push ? ~wptr_r : wptr_r;
    rptr_nxt = do_pop ? ~rptr_r : rptr_r;
    fill_nxt = fill_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

### hdl/tbfe_front.sv
`default_nettype none

module tbfe_front
  import tbfe_pkg::*;
#(
  parameter int TAG_BITS = 5,
  parameter int CHUNK_W  = TAG_BITS + 64,
  parameter int NB_W     = $clog2(CHUNK_W + 1),
  parameter int ENTRY_W  = 1 + NB_W + CHUNK_W
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [3:0]           in_operation,
  input  wire logic [63:0]          in_value,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [TAG_REG_W-1:0] cfg_wdata,
  output logic                      push_valid,
  input  wire logic                 push_ready,
  output logic [ENTRY_W-1:0]        push_data
);

  tag_t                tags_r [NUM_TAGS];
  logic [CHUNK_W-1:0]  bits;
  logic [NB_W-1:0]     nbits;
  logic                is_flush;
  logic                known_op;
  logic [TAG_BITS-1:0] t_bool, t_byte, t_u32, t_s32, t_u64, t_float, t_str, t_blob;

  // fit a 5-bit tag register to the stream tag width
  function automatic logic [TAG_BITS-1:0] fit_tag(input tag_t t);
    logic [TAG_BITS+TAG_REG_W-1:0] wide;
    wide = {{TAG_BITS{1'b0}}, t};
    return wide[TAG_BITS-1:0];
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TAGS; i++) begin
        tags_r[i] <= tag_reset_value(cfg_idx_t'(i[CFG_IDX_W-1:0]));
      end
    end else if (cfg_valid && cfg_ready) begin
      tags_r[cfg_index] <= cfg_wdata;
    end
  end

  assign t_bool  = fit_tag(tags_r[CFG_TAG_BOOL]);
  assign t_byte  = fit_tag(tags_r[CFG_TAG_BYTE]);
  assign t_u32   = fit_tag(tags_r[CFG_TAG_U32]);
  assign t_s32   = fit_tag(tags_r[CFG_TAG_S32]);
  assign t_u64   = fit_tag(tags_r[CFG_TAG_U64]);
  assign t_float = fit_tag(tags_r[CFG_TAG_FLOAT]);
  assign t_str   = fit_tag(tags_r[CFG_TAG_STRING]);
  assign t_blob  = fit_tag(tags_r[CFG_TAG_BLOB]);

  // classify the word into a run of stream bits, earliest bit at bit zero
  always_comb begin
    bits     = '0;
    nbits    = '0;
    is_flush = 1'b0;
    known_op = 1'b1;
    case (op_t'(in_operation))
      OP_BOOL: begin
        bits  = {{(CHUNK_W-TAG_BITS-1){1'b0}}, in_value[0], t_bool};
        nbits = NB_W'(TAG_BITS + 1);
      end
      OP_BYTE: begin
        bits  = {{(CHUNK_W-TAG_BITS-8){1'b0}}, in_value[7:0], t_byte};
        nbits = NB_W'(TAG_BITS + 8);
      end
      OP_U32: begin
        bits  = {{(CHUNK_W-TAG_BITS-32){1'b0}}, in_value[31:0], t_u32};
        nbits = NB_W'(TAG_BITS + 32);
      end
      OP_S32: begin
        bits  = {{(CHUNK_W-TAG_BITS-32){1'b0}}, in_value[31:0], t_s32};
        nbits = NB_W'(TAG_BITS + 32);
      end
      OP_U64: begin
        bits  = {in_value, t_u64};
        nbits = NB_W'(TAG_BITS + 64);
      end
      OP_FLOAT: begin
        bits  = {{(CHUNK_W-TAG_BITS-32){1'b0}}, in_value[31:0], t_float};
        nbits = NB_W'(TAG_BITS + 32);
      end
      OP_STRING: begin
        bits  = {{(CHUNK_W-TAG_BITS){1'b0}}, t_str};
        nbits = NB_W'(TAG_BITS);
      end
      OP_BLOB: begin
        // blob tag, then a typed u32 length
        bits  = {{(CHUNK_W-2*TAG_BITS-32){1'b0}}, in_value[31:0], t_u32, t_blob};
        nbits = NB_W'(2*TAG_BITS + 32);
      end
      OP_RAW: begin
        bits  = {{(CHUNK_W-8){1'b0}}, in_value[7:0]};
        nbits = NB_W'(8);
      end
      OP_FLUSH: begin
        is_flush = 1'b1;
      end
      default: begin
        known_op = 1'b0;
      end
    endcase
  end

  // unused codes are taken and dropped
  assign in_ready   = push_ready;
  assign push_valid = in_valid && known_op;
  assign push_data  = {is_flush, nbits, bits};

endmodule

`default_nettype wire

### hdl/tbfe_back.sv
`default_nettype none

module tbfe_back #(
  parameter int TAG_BITS = 5,
  parameter int CHUNK_W  = TAG_BITS + 64,
  parameter int NB_W     = $clog2(CHUNK_W + 1),
  parameter int ENTRY_W  = 1 + NB_W + CHUNK_W,
  parameter int ACC_W    = CHUNK_W + 7,
  parameter int CNT_W    = $clog2(ACC_W + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  output logic                    q_ready,
  input  wire logic [ENTRY_W-1:0] q_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_byte,
  output logic                    out_last_in_run,
  output logic                    out_end_of_stream
);

  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               eos_r, eos_nxt;
  logic               ovalid_r, ovalid_nxt;
  logic [7:0]         obyte_r;
  logic               olast_r, oeos_r;

  logic               emit, pop;
  logic [ACC_W-1:0]   base_acc;
  logic [CNT_W-1:0]   base_cnt;
  logic               e_flush;
  logic [NB_W-1:0]    e_nbits;
  logic [CHUNK_W-1:0] e_bits;
  logic [ACC_W-1:0]   merged;

  assign {e_flush, e_nbits, e_bits} = q_data;

  // one full byte leaves per cycle when the output register is free
  assign emit     = (cnt_r >= CNT_W'(8)) && (!ovalid_r || out_ready);
  assign base_acc = emit ? (acc_r >> 8) : acc_r;
  assign base_cnt = emit ? (cnt_r - CNT_W'(8)) : cnt_r;
  assign q_ready  = (base_cnt < CNT_W'(8));
  assign pop      = q_valid && q_ready;
  assign merged   = {{(ACC_W-7){1'b0}}, base_acc[6:0]}
                  | ({7'd0, e_bits} << base_cnt[2:0]);

  always_comb begin
    acc_nxt    = base_acc;
    cnt_nxt    = base_cnt;
    eos_nxt    = emit ? 1'b0 : eos_r;
    ovalid_nxt = emit ? 1'b1 : (ovalid_r && !out_ready);
    if (pop) begin
      if (e_flush) begin
        // pending bits go out as one zero-padded end byte
        if (base_cnt != '0) begin
          cnt_nxt = CNT_W'(8);
          eos_nxt = 1'b1;
        end
      end else begin
        acc_nxt = merged;
        cnt_nxt = base_cnt + CNT_W'(e_nbits);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      cnt_r    <= '0;
      eos_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      acc_r    <= acc_nxt;
      cnt_r    <= cnt_nxt;
      eos_r    <= eos_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      obyte_r <= acc_r[7:0];
      olast_r <= (cnt_r < CNT_W'(16));
      oeos_r  <= eos_r;
    end
  end

  assign out_valid         = ovalid_r;
  assign out_byte          = obyte_r;
  assign out_last_in_run   = olast_r;
  assign out_end_of_stream = oeos_r;

  a_eos_one_byte: assert property (@(posedge clk) disable iff (!rst_n)
    eos_r |-> (cnt_r == CNT_W'(8)))
    else $error("end byte pending with wrong bit count");

  a_clean_high: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_r >> cnt_r) == '0)
    else $error("stale bits above the fill count");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(ACC_W))
    else $error("fill count overflow");

  a_eos_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_end_of_stream) |-> out_last_in_run)
    else $error("end byte not marked last");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid)
    else $error("byte emitted without output word");

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import tbfe_pkg::*;

  localparam int TAG_BITS = 5;
  localparam int RUN_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 16;
  localparam logic [3:0] OP_UNUSED_FIRST = 4'd10;
  localparam logic [3:0] OP_UNUSED_LAST = 4'd15;
  localparam logic [63:0] ALL_ONES = {64{1'b1}};

  typedef struct packed {
    logic [7:0] data;
    logic       last_in_run;
    logic       end_of_stream;
  } stream_byte_t;

  // models the bit packer and holds the bytes it still owes
  class packed_byte_checker;
    tag_t         tag_regs[NUM_TAGS];
    logic [7:0]   acc_byte;
    int           acc_count;
    stream_byte_t expected_bytes[$];
    int           errors;

    function new();
      tag_regs[CFG_TAG_BOOL]   = 5'd1;
      tag_regs[CFG_TAG_BYTE]   = 5'd3;
      tag_regs[CFG_TAG_U32]    = 5'd8;
      tag_regs[CFG_TAG_S32]    = 5'd7;
      tag_regs[CFG_TAG_U64]    = 5'd10;
      tag_regs[CFG_TAG_FLOAT]  = 5'd13;
      tag_regs[CFG_TAG_STRING] = 5'd16;
      tag_regs[CFG_TAG_BLOB]   = 5'd19;
      acc_byte = '0;
      acc_count = 0;
      errors = 0;
    endfunction

    function void set_tag_reg(cfg_idx_t idx, tag_t val);
      tag_regs[idx] = val;
    endfunction

    function void push_bits(logic [63:0] bits, int count);
      for (int i = 0; i < count; i++) begin
        acc_byte[acc_count] = bits[i];
        acc_count++;
        if (acc_count == 8) begin
          expected_bytes.push_back('{acc_byte, 1'b0, 1'b0});
          acc_byte = '0;
          acc_count = 0;
        end
      end
    endfunction

    // tag bits above the register width go out as zero
    function void push_tag(cfg_idx_t which);
      logic [63:0] tag_bits;
      tag_bits = '0;
      tag_bits[TAG_REG_W-1:0] = tag_regs[which];
      push_bits(tag_bits, TAG_BITS);
    endfunction

    function void pack_word(logic [3:0] op, logic [63:0] val);
      int first;
      first = expected_bytes.size();
      case (op)
        OP_BOOL: begin
          push_tag(CFG_TAG_BOOL);
          push_bits(val, 1);
        end
        OP_BYTE: begin
          push_tag(CFG_TAG_BYTE);
          push_bits(val, 8);
        end
        OP_U32: begin
          push_tag(CFG_TAG_U32);
          push_bits(val, 32);
        end
        OP_S32: begin
          push_tag(CFG_TAG_S32);
          push_bits(val, 32);
        end
        OP_U64: begin
          push_tag(CFG_TAG_U64);
          push_bits(val, 64);
        end
        OP_FLOAT: begin
          push_tag(CFG_TAG_FLOAT);
          push_bits(val, 32);
        end
        OP_STRING: push_tag(CFG_TAG_STRING);
        OP_BLOB: begin
          push_tag(CFG_TAG_BLOB);
          push_tag(CFG_TAG_U32);
          push_bits(val, 32);
        end
        OP_RAW: push_bits(val, 8);
        OP_FLUSH: begin
          if (acc_count != 0) begin
            expected_bytes.push_back('{acc_byte, 1'b0, 1'b1});
            acc_byte = '0;
            acc_count = 0;
          end
        end
        default: ;
      endcase
      if (expected_bytes.size() > first)
        expected_bytes[expected_bytes.size() - 1].last_in_run = 1'b1;
    endfunction

    function void check_byte(logic [7:0] data, logic last, logic eos);
      stream_byte_t want;
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected byte %h (last %b, end %b)", $time, data, last, eos);
        return;
      end
      want = expected_bytes.pop_front();
      if (want.data !== data) begin
        errors++;
        $display("%0t: out_byte expected %h, actual %h", $time, want.data, data);
      end
      if (want.last_in_run !== last) begin
        errors++;
        $display("%0t: out_last_in_run expected %b, actual %b", $time, want.last_in_run, last);
      end
      if (want.end_of_stream !== eos) begin
        errors++;
        $display("%0t: out_end_of_stream expected %b, actual %b", $time,
                 want.end_of_stream, eos);
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [3:0]           in_operation = '0;
  logic [63:0]          in_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [7:0]           out_byte;
  logic                 out_last_in_run;
  logic                 out_end_of_stream;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TAG_REG_W-1:0] cfg_wdata = '0;

  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  int cycle_count = 0;
  packed_byte_checker checker_h = new();

  typed_bitstream_field_encoder #(
    .TAG_BITS(TAG_BITS)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_last_in_run  (out_last_in_run),
    .out_end_of_stream(out_end_of_stream),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  always @(posedge clk) begin
    if (in_valid && in_ready)
      checker_h.pack_word(in_operation, in_value);
    if (out_valid && out_ready)
      checker_h.check_byte(out_byte, out_last_in_run, out_end_of_stream);
    if (cfg_valid && cfg_ready)
      checker_h.set_tag_reg(cfg_idx_t'(cfg_index), cfg_wdata);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // starts and ends at a falling edge; valid stays up for the caller to lower
  task automatic send_word(input logic [3:0] op, input logic [63:0] val);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // a negative fill picks a random value per register
  task automatic load_tag_regs(input int fill);
    for (int i = 0; i < NUM_TAGS; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_wdata <= (fill < 0) ? tag_t'($urandom) : tag_t'(fill);
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (checker_h.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [63:0] pick_value();
    case ($urandom_range(9))
      0: return '0;
      1: return ALL_ONES;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_raw_run(input int count);
    for (int i = 0; i < count; i++) send_word(OP_RAW, pick_value());
  endtask

  // mostly typed words and string/blob runs with random content, plus noise
  task automatic run_random(input int count);
    int n;
    int pick;
    int len;
    int raw_count;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_word(op_t'($urandom_range(int'(OP_FLOAT), int'(OP_BOOL))), pick_value());
        n++;
      end else if (pick < 65) begin
        len = $urandom_range(6);
        send_word(OP_STRING, pick_value());
        send_raw_run(len);
        n += 1 + len;
      end else if (pick < 78) begin
        len = $urandom_range(6);
        // now and then the byte count disagrees with the declared length
        raw_count = ($urandom_range(9) == 0) ? $urandom_range(6) : len;
        send_word(OP_BLOB, {$urandom, 32'(len)});
        send_raw_run(raw_count);
        n += 1 + raw_count;
      end else if (pick < 86) begin
        send_word(OP_RAW, pick_value());
        n++;
      end else if (pick < 95) begin
        send_word(OP_FLUSH, pick_value());
        n++;
      end else begin
        send_word(4'($urandom_range(int'(OP_UNUSED_LAST), int'(OP_UNUSED_FIRST))),
                  pick_value());
      end
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    sender_idle_pct = 31;
    receiver_idle_pct = 56;
    // flush on an empty partial word, then field extremes with reset tags
    send_word(OP_FLUSH, '0);
    send_word(OP_BOOL, '0);
    send_word(OP_BOOL, ALL_ONES);
    send_word(OP_BYTE, '0);
    send_word(OP_BYTE, ALL_ONES);
    send_word(OP_U32, '0);
    send_word(OP_U32, ALL_ONES);
    send_word(OP_S32, 64'hFFFF_FFFF_8000_0000);
    send_word(OP_S32, 64'h0000_0000_7FFF_FFFF);
    send_word(OP_U64, '0);
    send_word(OP_U64, ALL_ONES);
    send_word(OP_FLOAT, 64'hA5A5_A5A5_3F80_0000);
    send_word(OP_STRING, ALL_ONES);
    send_raw_run(2);
    send_word(OP_BLOB, ALL_ONES);
    send_word(OP_BLOB, 64'hFFFF_FFFF_0000_0000);
    send_word(OP_RAW, 64'hFFFF_FFFF_FFFF_FF00);
    send_word(OP_RAW, 64'h0000_0000_0000_00A5);
    send_word(OP_BOOL, 64'd1);
    // flush twice on a byte-aligned stream, with no bits pending either time
    send_word(OP_FLUSH, '0);
    send_word(OP_FLUSH, ALL_ONES);
    for (int op = OP_UNUSED_FIRST; op <= OP_UNUSED_LAST; op++)
      send_word(4'(op), pick_value());
    send_word(OP_BYTE, 64'h5A);
    drain();

    load_tag_regs(0);
    run_random(100);
    drain();

    sender_idle_pct = 56;
    receiver_idle_pct = 31;
    load_tag_regs(31);
    run_random(100);
    drain();

    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    load_tag_regs(-1);
    run_random(100);
    send_word(OP_FLUSH, '0);
    drain();

    if (checker_h.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
hdl/tbfe_pkg.sv
hdl/tbfe_queue.sv
hdl/tbfe_front.sv
hdl/tbfe_back.sv
hdl/typed_bitstream_field_encoder.sv
tb/testbench.sv
